@@ rtl/core/pidfd_pkg.sv @@
// Package for the filtered-derivative PID controller with anti-windup.
// Holds the item types, fixed-point widths, register and clamp codes,
// the controller-to-datapath command types and the saturation helper.
package pidfd_pkg;

   localparam int SIG_W          = 16;
   localparam int ACC_W          = 32;
   localparam int FRAC_BITS      = 16;
   localparam int POLE_W         = 17;
   localparam int COEF_WIDTH_DEF = 32;
   localparam int CSR_IDX_W      = 3;
   localparam int COEF_ONE       = 65536;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT_WEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_POLE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_MIN       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_MAX       = 3'd6;

   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_MIN  = 2'd1;
   localparam logic [1:0] CLAMP_MAX  = 2'd2;

   localparam int MUL_SEL_W = 3;
   localparam logic [MUL_SEL_W-1:0] MUL_SW   = 3'd0;
   localparam logic [MUL_SEL_W-1:0] MUL_POLE = 3'd1;
   localparam logic [MUL_SEL_W-1:0] MUL_DG   = 3'd2;
   localparam logic [MUL_SEL_W-1:0] MUL_KP   = 3'd3;
   localparam logic [MUL_SEL_W-1:0] MUL_KI   = 3'd4;

   typedef struct packed {
      logic signed [SIG_W-1:0] measured;
      logic signed [SIG_W-1:0] setpoint;
   } req_item_type;

   typedef struct packed {
      logic signed [SIG_W-1:0] drive;
      logic [1:0]              clamp_state;
   } rsp_item_type;

   typedef struct packed {
      logic                 load_in;
      logic [MUL_SEL_W-1:0] mul_sel;
      logic                 ld_pe;
      logic                 ld_d_pole;
      logic                 ld_d_sub;
      logic                 ld_u;
      logic                 commit;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic rsp_pending;
   } dp_status_type;

   // Saturates a sum of accumulator values to the signed accumulator width.
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
      logic [2:0] top;
      top = v[ACC_W+1:ACC_W-1];
      if ((top == 3'b000) || (top == 3'b111)) begin
         return v[ACC_W-1:0];
      end else if (v[ACC_W+1]) begin
         return {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         return {1'b0, {(ACC_W-1){1'b1}}};
      end
   endfunction

endpackage

@@ rtl/core/pidfd_csr.sv @@
// Configuration registers of the PID controller: gains, filter pole and limits.
// Depends on pidfd_pkg for widths, reset values and register indexes.
module pidfd_csr #(
   parameter int COEF_WIDTH = pidfd_pkg::COEF_WIDTH_DEF,
   parameter int CSR_DW     = (COEF_WIDTH > pidfd_pkg::POLE_W) ? COEF_WIDTH : pidfd_pkg::POLE_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pidfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DW-1:0]                   csr_data,
   output logic signed [COEF_WIDTH-1:0]        prop_gain,
   output logic signed [COEF_WIDTH-1:0]        setpoint_weight,
   output logic [pidfd_pkg::POLE_W-1:0]        deriv_pole,
   output logic signed [COEF_WIDTH-1:0]        deriv_gain,
   output logic signed [COEF_WIDTH-1:0]        integ_gain,
   output logic signed [pidfd_pkg::SIG_W-1:0]  drive_min,
   output logic signed [pidfd_pkg::SIG_W-1:0]  drive_max
);
   import pidfd_pkg::*;

   logic signed [COEF_WIDTH-1:0] prop_gain_ff;
   logic signed [COEF_WIDTH-1:0] setpoint_weight_ff;
   logic [POLE_W-1:0]            deriv_pole_ff;
   logic signed [COEF_WIDTH-1:0] deriv_gain_ff;
   logic signed [COEF_WIDTH-1:0] integ_gain_ff;
   logic signed [SIG_W-1:0]      drive_min_ff;
   logic signed [SIG_W-1:0]      drive_max_ff;
   logic                         wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff       <= COEF_WIDTH'(COEF_ONE);
         setpoint_weight_ff <= COEF_WIDTH'(COEF_ONE);
         deriv_pole_ff      <= '0;
         deriv_gain_ff      <= '0;
         integ_gain_ff      <= '0;
         drive_min_ff       <= {1'b1, {(SIG_W-1){1'b0}}};
         drive_max_ff       <= {1'b0, {(SIG_W-1){1'b1}}};
      end else if (wr_en) begin
         case (csr_index)
            REG_PROP_GAIN:       prop_gain_ff       <= csr_data[COEF_WIDTH-1:0];
            REG_SETPOINT_WEIGHT: setpoint_weight_ff <= csr_data[COEF_WIDTH-1:0];
            REG_DERIV_POLE:      deriv_pole_ff      <= csr_data[POLE_W-1:0];
            REG_DERIV_GAIN:      deriv_gain_ff      <= csr_data[COEF_WIDTH-1:0];
            REG_INTEG_GAIN:      integ_gain_ff      <= csr_data[COEF_WIDTH-1:0];
            REG_DRIVE_MIN:       drive_min_ff       <= csr_data[SIG_W-1:0];
            REG_DRIVE_MAX:       drive_max_ff       <= csr_data[SIG_W-1:0];
            default: ;
         endcase
      end
   end

   assign prop_gain       = prop_gain_ff;
   assign setpoint_weight = setpoint_weight_ff;
   assign deriv_pole      = deriv_pole_ff;
   assign deriv_gain      = deriv_gain_ff;
   assign integ_gain      = integ_gain_ff;
   assign drive_min       = drive_min_ff;
   assign drive_max       = drive_max_ff;

endmodule

@@ rtl/core/pidfd_ctrl.sv @@
// Sequencer of the PID controller: schedules the shared multiplier and sums.
// Depends on pidfd_pkg for the command and status types and select codes.
module pidfd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pidfd_pkg::dp_status_type status,
   output pidfd_pkg::dp_cmd_type    cmd
);
   import pidfd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MPE   = 3'd1;
   localparam logic [2:0] ST_MPOLE = 3'd2;
   localparam logic [2:0] ST_MDG   = 3'd3;
   localparam logic [2:0] ST_MKP   = 3'd4;
   localparam logic [2:0] ST_MKI   = 3'd5;
   localparam logic [2:0] ST_SUM   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mul_sel   = MUL_KI;
      cmd.load_in   = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MPE;
         end
         ST_MPE: begin
            cmd.mul_sel = MUL_SW;
            state_in    = ST_MPOLE;
         end
         ST_MPOLE: begin
            cmd.mul_sel = MUL_POLE;
            state_in    = ST_MDG;
         end
         ST_MDG: begin
            cmd.mul_sel = MUL_DG;
            cmd.ld_pe   = 1'b1;
            state_in    = ST_MKP;
         end
         ST_MKP: begin
            cmd.mul_sel   = MUL_KP;
            cmd.ld_d_pole = 1'b1;
            state_in      = ST_MKI;
         end
         ST_MKI: begin
            cmd.ld_d_sub = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.ld_u = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MPE))
      else $error("Accepted item did not start the multiply sequence.");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && !status.rsp_free |=> (state_ff == ST_OUT))
      else $error("Result left the output state without a free slot.");

   a_commit_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> status.rsp_pending)
      else $error("Committed item did not reach the output register.");

endmodule

@@ rtl/core/pidfd_dpath.sv @@
// Datapath of the PID controller: shared rounding multiplier, D/I/P terms,
// clamp and output register. Depends on pidfd_pkg for types and helpers.
module pidfd_dpath #(
   parameter int COEF_WIDTH = pidfd_pkg::COEF_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pidfd_pkg::dp_cmd_type               cmd,
   output pidfd_pkg::dp_status_type            status,
   input  pidfd_pkg::req_item_type             req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pidfd_pkg::rsp_item_type             rsp_item,
   input  logic signed [COEF_WIDTH-1:0]        prop_gain,
   input  logic signed [COEF_WIDTH-1:0]        setpoint_weight,
   input  logic [pidfd_pkg::POLE_W-1:0]        deriv_pole,
   input  logic signed [COEF_WIDTH-1:0]        deriv_gain,
   input  logic signed [COEF_WIDTH-1:0]        integ_gain,
   input  logic signed [pidfd_pkg::SIG_W-1:0]  drive_min,
   input  logic signed [pidfd_pkg::SIG_W-1:0]  drive_max
);
   import pidfd_pkg::*;

   localparam int OPA_W = (COEF_WIDTH > POLE_W + 1) ? COEF_WIDTH : POLE_W + 1;
   localparam int OPB_W = (ACC_W > SIG_W + 1) ? ACC_W : SIG_W + 1;
   localparam int PW    = OPA_W + OPB_W;

   logic signed [SIG_W-1:0] y_ff;
   logic signed [SIG_W-1:0] r_ff;
   logic signed [SIG_W-1:0] prev_ff;
   logic signed [ACC_W-1:0] deriv_ff;
   logic signed [ACC_W-1:0] integ_ff;
   logic signed [ACC_W-1:0] pe_ff;
   logic signed [ACC_W-1:0] u_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    prod_in;
   logic signed [ACC_W-1:0] q_ff;
   logic signed [ACC_W-1:0] q_in;
   logic                    rsp_valid_ff;
   rsp_item_type            rsp_item_ff;

   logic signed [OPA_W-1:0] opa;
   logic signed [OPB_W-1:0] opb;
   logic signed [SIG_W:0]   dy;
   logic signed [SIG_W:0]   err;
   logic signed [PW:0]      rnd;
   logic signed [PW:0]      shifted;
   logic signed [ACC_W-1:0] lim_lo;
   logic signed [ACC_W-1:0] lim_hi;
   logic [1:0]              clamp;
   logic signed [SIG_W-1:0] drive_val;
   logic                    rsp_free;

   assign dy  = (SIG_W+1)'(y_ff) - (SIG_W+1)'(prev_ff);
   assign err = (SIG_W+1)'(r_ff) - (SIG_W+1)'(y_ff);

   always_comb begin
      case (cmd.mul_sel)
         MUL_SW: begin
            opa = OPA_W'(setpoint_weight);
            opb = OPB_W'(r_ff);
         end
         MUL_POLE: begin
            opa = OPA_W'({1'b0, deriv_pole});
            opb = OPB_W'(deriv_ff);
         end
         MUL_DG: begin
            opa = OPA_W'(deriv_gain);
            opb = OPB_W'(dy);
         end
         MUL_KP: begin
            opa = OPA_W'(prop_gain);
            opb = OPB_W'(pe_ff);
         end
         MUL_KI: begin
            opa = OPA_W'(integ_gain);
            opb = OPB_W'(err);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign prod_in = opa * opb;

   // Round half toward plus infinity from Q.16 to Q.0, then saturate.
   assign rnd     = (PW+1)'(prod_ff) + (PW+1)'(1 << (FRAC_BITS - 1));
   assign shifted = rnd >>> FRAC_BITS;

   always_comb begin
      if ((shifted[PW:ACC_W-1] == '0) || (shifted[PW:ACC_W-1] == '1)) begin
         q_in = shifted[ACC_W-1:0];
      end else if (shifted[PW]) begin
         q_in = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         q_in = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   assign lim_lo = ACC_W'(drive_min);
   assign lim_hi = ACC_W'(drive_max);

   always_comb begin
      clamp     = CLAMP_NONE;
      drive_val = u_ff[SIG_W-1:0];
      if (u_ff < lim_lo) begin
         clamp     = CLAMP_MIN;
         drive_val = drive_min;
      end
      if (u_ff > lim_hi) begin
         clamp     = CLAMP_MAX;
         drive_val = drive_max;
      end
   end

   assign rsp_free           = !rsp_valid_ff || !rsp_stall;
   assign status.rsp_free    = rsp_free;
   assign status.rsp_pending = rsp_valid_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q_ff    <= q_in;
      if (cmd.load_in) begin
         y_ff <= req_item.measured;
         r_ff <= req_item.setpoint;
      end
      if (cmd.ld_pe) begin
         pe_ff <= sat_acc((ACC_W+2)'(q_ff) - (ACC_W+2)'(y_ff));
      end
      if (cmd.ld_u) begin
         u_ff <= sat_acc((ACC_W+2)'(q_ff) + (ACC_W+2)'(integ_ff) + (ACC_W+2)'(deriv_ff));
      end
      if (cmd.commit) begin
         rsp_item_ff.drive       <= drive_val;
         rsp_item_ff.clamp_state <= clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         deriv_ff     <= '0;
         integ_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.ld_d_pole) begin
            deriv_ff <= q_ff;
         end else if (cmd.ld_d_sub) begin
            deriv_ff <= sat_acc((ACC_W+2)'(deriv_ff) - (ACC_W+2)'(q_ff));
         end
         if (cmd.commit) begin
            prev_ff <= y_ff;
            if (clamp == CLAMP_NONE) begin
               integ_ff <= sat_acc((ACC_W+2)'(integ_ff) + (ACC_W+2)'(q_ff));
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> rsp_free)
      else $error("Output register overwritten while an item was still held.");

   a_clamp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.clamp_state != 2'b11))
      else $error("Result item carries an unused clamp code.");

   a_unclamped_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (clamp == CLAMP_NONE) |-> (u_ff >= lim_lo) && (u_ff <= lim_hi))
      else $error("Unclamped drive lies outside the actuator limits.");

endmodule

@@ rtl/core/pid_filtered_derivative_antiwindup.sv @@
// Discrete PID controller with setpoint weighting, filtered derivative and
// conditional-integration anti-windup. A new item is accepted only once the
// previous one is committed to the output register, which rsp_stall delays;
// the single shared multiplier and rounding register serve five products
// per item. Reset is synchronous: gains and limits return to defaults, D, I
// and the previous sample clear to zero. Uses pidfd_pkg and pidfd_* modules.
module pid_filtered_derivative_antiwindup #(
   parameter int COEF_WIDTH = pidfd_pkg::COEF_WIDTH_DEF,
   parameter int CSR_DW     = (COEF_WIDTH > pidfd_pkg::POLE_W) ? COEF_WIDTH : pidfd_pkg::POLE_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pidfd_pkg::req_item_type         req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pidfd_pkg::rsp_item_type         rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pidfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DW-1:0]               csr_data
);
   import pidfd_pkg::*;

   logic signed [COEF_WIDTH-1:0] prop_gain;
   logic signed [COEF_WIDTH-1:0] setpoint_weight;
   logic [POLE_W-1:0]            deriv_pole;
   logic signed [COEF_WIDTH-1:0] deriv_gain;
   logic signed [COEF_WIDTH-1:0] integ_gain;
   logic signed [SIG_W-1:0]      drive_min;
   logic signed [SIG_W-1:0]      drive_max;
   dp_cmd_type                   cmd;
   dp_status_type                status;

   pidfd_csr #(
      .COEF_WIDTH (COEF_WIDTH),
      .CSR_DW     (CSR_DW)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .prop_gain       (prop_gain),
      .setpoint_weight (setpoint_weight),
      .deriv_pole      (deriv_pole),
      .deriv_gain      (deriv_gain),
      .integ_gain      (integ_gain),
      .drive_min       (drive_min),
      .drive_max       (drive_max)
   );

   pidfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pidfd_dpath #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .prop_gain       (prop_gain),
      .setpoint_weight (setpoint_weight),
      .deriv_pole      (deriv_pole),
      .deriv_gain      (deriv_gain),
      .integ_gain      (integ_gain),
      .drive_min       (drive_min),
      .drive_max       (drive_max)
   );

endmodule
